/* rtl/i2c_eeprom_pkg.sv */
// package for the i2c eeprom byte access master
// holds field widths, register indexes, reset values, the operation type and the sequencer phase type
// no dependencies
`timescale 1ns / 1ps

package i2c_eeprom_pkg;

    localparam int WAIT_COUNT_BITS = 20;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int S_TDATA_BITS    = 24;
    localparam int S_TUSER_BITS    = 2;
    localparam int M_TDATA_BITS    = 16;

    // register indexes on the configuration port
    localparam logic REG_DEVICE_ADDRESS   = 1'b0;
    localparam logic REG_WRITE_WAIT_TICKS = 1'b1;

    localparam logic [6:0]                 DEVICE_ADDRESS_RESET   = 7'd80;
    localparam logic [WAIT_COUNT_BITS-1:0] WRITE_WAIT_TICKS_RESET = WAIT_COUNT_BITS'(1000);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'b0000_0000_0000_0001,
        PH_ST_A    = 16'b0000_0000_0000_0010,
        PH_ST_B    = 16'b0000_0000_0000_0100,
        PH_TX_DEVW = 16'b0000_0000_0000_1000,
        PH_TX_ADDR = 16'b0000_0000_0001_0000,
        PH_TX_DATA = 16'b0000_0000_0010_0000,
        PH_RS_A    = 16'b0000_0000_0100_0000,
        PH_RS_B    = 16'b0000_0000_1000_0000,
        PH_RS_C    = 16'b0000_0001_0000_0000,
        PH_RS_D    = 16'b0000_0010_0000_0000,
        PH_TX_DEVR = 16'b0000_0100_0000_0000,
        PH_RX      = 16'b0000_1000_0000_0000,
        PH_SP_A    = 16'b0001_0000_0000_0000,
        PH_SP_B    = 16'b0010_0000_0000_0000,
        PH_SP_C    = 16'b0100_0000_0000_0000,
        PH_WAIT    = 16'b1000_0000_0000_0000
    } phase_t;

endpackage

/* rtl/i2c_eeprom_byte_access_master_core.sv */
// i2c eeprom byte access master: half-bit sequencer with apb configuration
// depends on i2c_eeprom_pkg
`timescale 1ns / 1ps

// usage
// each input word on the s_ channel is one half-bit tick of the bus clock. it carries
// the sampled sda level and, while the block is idle, an optional byte write or byte
// read request (s_tuser). every accepted tick produces exactly one result word on the
// m_ channel with the scl/sda drive levels, busy, done and the last byte read.
// a write runs start, device write address, memory address, data, stop and then stays
// busy for write_wait_ticks ticks; a read runs start, device address, memory address,
// repeated start, device read address, eight data bits, a not-acknowledge clock, stop.
// the result of a tick is registered and valid in the cycle after it is accepted.
// throughput: one tick per cycle while no result word is stalled; the sequencer
// state and the result register are both updated in the accepting cycle.
// when the receiver stalls, the result register holds its word and s_tready drops only
// while that word is stalled, so no tick is lost or repeated.
// reset (aresetn low, synchronous) returns the sequencer to idle, empties the result
// register and loads device_address 0x50 and write_wait_ticks 1000.
// user must write configuration at apb byte addresses 0 and 4 while idle; unenforced.
module i2c_eeprom_byte_access_master_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [7:0] mem_address, [15:8] write_data, [16] sda_in, [23:17] zero
    input  logic [i2c_eeprom_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [1:0] operation
    input  logic [i2c_eeprom_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res, [11:4] read_data,
    // [15:12] zero
    output logic [i2c_eeprom_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [i2c_eeprom_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    import i2c_eeprom_pkg::*;

    logic [6:0]                 device_address_reg;
    logic [WAIT_COUNT_BITS-1:0] write_wait_ticks_reg;

    phase_t                     phase_reg, phase_next;
    logic                       half_bit_reg, half_bit_next;
    logic [3:0]                 bit_count_reg, bit_count_next;
    logic [7:0]                 shift_byte_reg, shift_byte_next;
    logic [7:0]                 latched_address_reg, latched_address_next;
    logic [7:0]                 latched_data_reg, latched_data_next;
    logic                       is_read_reg, is_read_next;
    logic [WAIT_COUNT_BITS-1:0] wait_count_reg, wait_count_next;
    logic [7:0]                 last_read_reg, last_read_next;

    logic                       m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]    m_tdata_reg, m_tdata_next;

    logic                       s_accept;
    logic                       cfg_write;
    op_t                        op;
    logic [7:0]                 in_mem_address;
    logic [7:0]                 in_write_data;
    logic                       in_sda;
    logic                       scl_o, sda_o, busy_o, done_o;
    logic                       byte_end;
    phase_t                     cur_phase;
    logic [WAIT_COUNT_BITS-1:0] wait_dec;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            REG_DEVICE_ADDRESS:   prdata = {25'd0, device_address_reg};
            REG_WRITE_WAIT_TICKS: prdata = 32'(write_wait_ticks_reg);
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg   <= DEVICE_ADDRESS_RESET;
            write_wait_ticks_reg <= WRITE_WAIT_TICKS_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_DEVICE_ADDRESS:   device_address_reg <= pwdata[6:0];
                REG_WRITE_WAIT_TICKS: write_wait_ticks_reg <= pwdata[WAIT_COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // result register frees up when its word is taken
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign op             = op_t'(s_tuser[1:0]);
    assign in_mem_address = s_tdata[7:0];
    assign in_write_data  = s_tdata[15:8];
    assign in_sda         = s_tdata[16];
    assign wait_dec       = wait_count_reg - WAIT_COUNT_BITS'(1);

    always_comb begin
        phase_next           = phase_reg;
        half_bit_next        = half_bit_reg;
        bit_count_next       = bit_count_reg;
        shift_byte_next      = shift_byte_reg;
        latched_address_next = latched_address_reg;
        latched_data_next    = latched_data_reg;
        is_read_next         = is_read_reg;
        wait_count_next      = wait_count_reg;
        last_read_next       = last_read_reg;
        scl_o                = 1'b1;
        sda_o                = 1'b1;
        busy_o               = 1'b1;
        done_o               = 1'b0;
        byte_end             = 1'b0;
        cur_phase            = phase_reg;

        // a request in idle starts the first start tick in the same cycle
        if (phase_reg == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
            latched_address_next = in_mem_address;
            latched_data_next    = in_write_data;
            is_read_next         = (op == OP_READ);
            cur_phase            = PH_ST_A;
        end

        unique case (cur_phase)
            PH_ST_A: begin
                sda_o      = 1'b0;
                phase_next = PH_ST_B;
            end
            PH_ST_B: begin
                scl_o           = 1'b0;
                sda_o           = 1'b0;
                phase_next      = PH_TX_DEVW;
                shift_byte_next = {device_address_reg, 1'b0};
                bit_count_next  = 4'd0;
                half_bit_next   = 1'b0;
            end
            PH_TX_DEVW, PH_TX_ADDR, PH_TX_DATA, PH_TX_DEVR: begin
                scl_o = half_bit_reg;
                if (!bit_count_reg[3]) begin
                    sda_o = shift_byte_reg[7];
                    if (half_bit_reg) begin
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        bit_count_next  = bit_count_reg + 4'd1;
                    end
                end else begin
                    // acknowledge clock, data line released
                    sda_o    = 1'b1;
                    byte_end = half_bit_reg;
                end
                half_bit_next = ~half_bit_reg;
                if (byte_end) begin
                    bit_count_next = 4'd0;
                    half_bit_next  = 1'b0;
                    unique case (cur_phase)
                        PH_TX_DEVW: begin
                            phase_next      = PH_TX_ADDR;
                            shift_byte_next = latched_address_reg;
                        end
                        PH_TX_ADDR: begin
                            if (is_read_reg) begin
                                phase_next     = PH_RS_A;
                                bit_count_next = bit_count_reg;
                                half_bit_next  = ~half_bit_reg;
                            end else begin
                                phase_next      = PH_TX_DATA;
                                shift_byte_next = latched_data_reg;
                            end
                        end
                        PH_TX_DATA: begin
                            phase_next     = PH_SP_A;
                            bit_count_next = bit_count_reg;
                            half_bit_next  = ~half_bit_reg;
                        end
                        default: begin
                            phase_next      = PH_RX;
                            shift_byte_next = 8'd0;
                        end
                    endcase
                end
            end
            PH_RS_A: begin
                scl_o      = 1'b0;
                phase_next = PH_RS_B;
            end
            PH_RS_B: begin
                phase_next = PH_RS_C;
            end
            PH_RS_C: begin
                sda_o      = 1'b0;
                phase_next = PH_RS_D;
            end
            PH_RS_D: begin
                scl_o           = 1'b0;
                sda_o           = 1'b0;
                phase_next      = PH_TX_DEVR;
                shift_byte_next = {device_address_reg, 1'b1};
                bit_count_next  = 4'd0;
                half_bit_next   = 1'b0;
            end
            PH_RX: begin
                scl_o = half_bit_reg;
                if (!bit_count_reg[3]) begin
                    if (half_bit_reg) begin
                        shift_byte_next = {shift_byte_reg[6:0], in_sda};
                        bit_count_next  = bit_count_reg + 4'd1;
                    end
                end else if (half_bit_reg) begin
                    phase_next = PH_SP_A;
                end
                half_bit_next = ~half_bit_reg;
            end
            PH_SP_A: begin
                scl_o      = 1'b0;
                sda_o      = 1'b0;
                phase_next = PH_SP_B;
            end
            PH_SP_B: begin
                sda_o      = 1'b0;
                phase_next = PH_SP_C;
            end
            PH_SP_C: begin
                if (is_read_reg) begin
                    last_read_next = shift_byte_reg;
                    done_o         = 1'b1;
                    busy_o         = 1'b0;
                    phase_next     = PH_IDLE;
                end else if (write_wait_ticks_reg == '0) begin
                    done_o     = 1'b1;
                    busy_o     = 1'b0;
                    phase_next = PH_IDLE;
                end else begin
                    wait_count_next = write_wait_ticks_reg;
                    phase_next      = PH_WAIT;
                end
            end
            PH_WAIT: begin
                wait_count_next = wait_dec;
                if (wait_dec == '0) begin
                    done_o     = 1'b1;
                    busy_o     = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                busy_o     = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase

        m_tdata_next = {4'd0, last_read_next, done_o, busy_o, sda_o, scl_o};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            half_bit_reg        <= 1'b0;
            bit_count_reg       <= 4'd0;
            shift_byte_reg      <= 8'd0;
            latched_address_reg <= 8'd0;
            latched_data_reg    <= 8'd0;
            is_read_reg         <= 1'b0;
            wait_count_reg      <= '0;
            last_read_reg       <= 8'd0;
            m_tvalid_reg        <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg           <= phase_next;
                half_bit_reg        <= half_bit_next;
                bit_count_reg       <= bit_count_next;
                shift_byte_reg      <= shift_byte_next;
                latched_address_reg <= latched_address_next;
                latched_data_reg    <= latched_data_next;
                is_read_reg         <= is_read_next;
                wait_count_reg      <= wait_count_next;
                last_read_reg       <= last_read_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

/* rtl/i2c_eeprom_chk.sv */
// port-level checker for the i2c eeprom byte access master, with its bind
// depends on i2c_eeprom_pkg and the top level i2c_eeprom_byte_access_master_core
`timescale 1ns / 1ps

module i2c_eeprom_chk (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [i2c_eeprom_pkg::M_TDATA_BITS-1:0] m_tdata
);

    import i2c_eeprom_pkg::*;

    // a stalled result word holds still
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // completion never reports busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done reported together with busy");

    // whenever the block is not busy both bus lines are released
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
        else $error("bus driven while not busy");

    // one result word per tick: a tick taken while the output is free shows up next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no result word");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind i2c_eeprom_byte_access_master_core i2c_eeprom_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// testbench for the i2c eeprom byte access master core
// drives half-bit ticks and apb register writes, predicts the bus drive words and checks them
// depends on i2c_eeprom_pkg and i2c_eeprom_byte_access_master_core
`timescale 1ns / 1ps

module testbench;
    import i2c_eeprom_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 5;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_DEVICE = {REG_DEVICE_ADDRESS, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_WAIT   = {REG_WRITE_WAIT_TICKS, 2'b00};

    typedef struct packed {
        logic [6:0] zero;
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] mem_address;
    } tick_word_t;

    typedef struct packed {
        logic [3:0] zero;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } bus_word_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata = '0;
    logic [S_TUSER_BITS-1:0]  s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    i2c_eeprom_byte_access_master_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // sequencer model state
    phase_t                     ph = PH_IDLE;
    logic                       half_hi = 1'b0;
    logic [3:0]                 bit_cnt = '0;
    logic [7:0]                 shift_reg = '0;
    logic [7:0]                 req_addr = '0;
    logic [7:0]                 req_data = '0;
    logic                       req_is_read = 1'b0;
    logic [WAIT_COUNT_BITS-1:0] wait_left = '0;
    logic [7:0]                 rx_byte = '0;
    logic [6:0]                 cfg_device = DEVICE_ADDRESS_RESET;
    logic [WAIT_COUNT_BITS-1:0] cfg_wait = WRITE_WAIT_TICKS_RESET;

    bus_word_t expected_bus_words[$];
    int err_cnt = 0;
    int tick_cnt = 0;
    int write_cnt = 0;
    int read_cnt = 0;
    int ignored_req_cnt = 0;
    int cycle_cnt = 0;
    int src_idle_pct = 19;
    int sink_idle_pct = 51;

    function automatic void load_byte(phase_t next, logic [7:0] value);
        ph = next;
        shift_reg = value;
        bit_cnt = '0;
        half_hi = 1'b0;
    endfunction

    function automatic bus_word_t predict_bus_tick(op_t op, logic [7:0] addr, logic [7:0] data,
                                                   logic sda);
        bus_word_t r;
        logic byte_end;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_release = 1'b1;
        r.busy_res = 1'b1;
        byte_end = 1'b0;
        if (op == OP_WRITE || op == OP_READ) begin
            if (ph == PH_IDLE) begin
                req_addr = addr;
                req_data = data;
                req_is_read = (op == OP_READ);
                ph = PH_ST_A;
                if (op == OP_READ) read_cnt++;
                else write_cnt++;
            end else begin
                ignored_req_cnt++;
            end
        end
        case (ph)
            PH_ST_A: begin
                r.sda_release = 1'b0;
                ph = PH_ST_B;
            end
            PH_ST_B: begin
                r.scl_level = 1'b0;
                r.sda_release = 1'b0;
                load_byte(PH_TX_DEVW, {cfg_device, 1'b0});
            end
            PH_TX_DEVW, PH_TX_ADDR, PH_TX_DATA, PH_TX_DEVR: begin
                r.scl_level = half_hi;
                if (bit_cnt < 4'd8) begin
                    r.sda_release = shift_reg[7];
                    if (half_hi) begin
                        shift_reg = shift_reg << 1;
                        bit_cnt++;
                    end
                end else begin
                    // ack clock: line released, slave answer not looked at
                    byte_end = half_hi;
                end
                half_hi = ~half_hi;
                if (byte_end) begin
                    case (ph)
                        PH_TX_DEVW: load_byte(PH_TX_ADDR, req_addr);
                        PH_TX_ADDR: begin
                            if (req_is_read) ph = PH_RS_A;
                            else load_byte(PH_TX_DATA, req_data);
                        end
                        PH_TX_DATA: ph = PH_SP_A;
                        default: load_byte(PH_RX, 8'h00);
                    endcase
                end
            end
            PH_RS_A: begin
                r.scl_level = 1'b0;
                ph = PH_RS_B;
            end
            PH_RS_B: ph = PH_RS_C;
            PH_RS_C: begin
                r.sda_release = 1'b0;
                ph = PH_RS_D;
            end
            PH_RS_D: begin
                r.scl_level = 1'b0;
                r.sda_release = 1'b0;
                load_byte(PH_TX_DEVR, {cfg_device, 1'b1});
            end
            PH_RX: begin
                r.scl_level = half_hi;
                if (bit_cnt < 4'd8) begin
                    if (half_hi) begin
                        shift_reg = {shift_reg[6:0], sda};
                        bit_cnt++;
                    end
                end else if (half_hi) begin
                    ph = PH_SP_A;
                end
                half_hi = ~half_hi;
            end
            PH_SP_A: begin
                r.scl_level = 1'b0;
                r.sda_release = 1'b0;
                ph = PH_SP_B;
            end
            PH_SP_B: begin
                r.sda_release = 1'b0;
                ph = PH_SP_C;
            end
            PH_SP_C: begin
                if (req_is_read || cfg_wait == '0) begin
                    if (req_is_read) rx_byte = shift_reg;
                    r.done_res = 1'b1;
                    r.busy_res = 1'b0;
                    ph = PH_IDLE;
                end else begin
                    wait_left = cfg_wait;
                    ph = PH_WAIT;
                end
            end
            PH_WAIT: begin
                wait_left = wait_left - 1'b1;
                if (wait_left == '0) begin
                    r.done_res = 1'b1;
                    r.busy_res = 1'b0;
                    ph = PH_IDLE;
                end
            end
            default: begin
                r.busy_res = 1'b0;
                ph = PH_IDLE;
            end
        endcase
        r.read_data = rx_byte;
        return r;
    endfunction

    // one tick word, held until the core takes it
    task automatic send_tick(op_t op, logic [7:0] addr, logic [7:0] data, logic sda);
        tick_word_t w;
        w = '0;
        w.mem_address = addr;
        w.write_data = data;
        w.sda_in = sda;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= op;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        expected_bus_words.push_back(predict_bus_tick(op, addr, data, sda));
        tick_cnt++;
    endtask

    // request plus ticks until the access is over; sda_byte is what the slave returns
    task automatic run_access(op_t op, logic [7:0] addr, logic [7:0] data,
                              logic [7:0] sda_byte, int noise_pct, op_t busy_op);
        op_t o;
        logic sda;
        send_tick(op, addr, data, 1'($urandom_range(1)));
        while (ph != PH_IDLE) begin
            o = ($urandom_range(99) < noise_pct) ? busy_op : OP_TICK;
            if (ph == PH_RX && half_hi && bit_cnt < 4'd8) sda = sda_byte[3'(4'd7 - bit_cnt)];
            else sda = 1'($urandom_range(1));
            send_tick(o, 8'($urandom), 8'($urandom), sda);
        end
    endtask

    task automatic drain_to_idle();
        while (ph != PH_IDLE) send_tick(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bus_words.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        rdata = prdata;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, addr, '0, got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: register at 0x%0h expected %0h got %0h", $time, addr, want, got);
        end
    endtask

    task automatic set_config(logic [6:0] device, logic [WAIT_COUNT_BITS-1:0] wait_ticks);
        logic [31:0] unused;
        drain_to_idle();
        apb_access(1'b1, ADDR_DEVICE, 32'(device), unused);
        apb_access(1'b1, ADDR_WAIT, 32'(wait_ticks), unused);
        cfg_device = device;
        cfg_wait = wait_ticks;
        check_reg(ADDR_DEVICE, 32'(device));
        check_reg(ADDR_WAIT, 32'(wait_ticks));
    endtask

    function automatic logic [WAIT_COUNT_BITS-1:0] pick_wait();
        case ($urandom_range(15))
            0, 1: return '0;
            2: return WAIT_COUNT_BITS'(1);
            3: return WAIT_COUNT_BITS'($urandom_range(100, 300));
            default: return WAIT_COUNT_BITS'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic test_reset_values();
        check_reg(ADDR_DEVICE, 32'(DEVICE_ADDRESS_RESET));
        check_reg(ADDR_WAIT, 32'(WRITE_WAIT_TICKS_RESET));
        // idle ticks, including the unused operation code
        send_tick(OP_TICK, 8'h00, 8'h00, 1'b0);
        send_tick(OP_NONE, 8'hFF, 8'hFF, 1'b1);
        send_tick(OP_NONE, 8'h00, 8'hFF, 1'b0);
        send_tick(OP_TICK, 8'hFF, 8'h00, 1'b1);
    endtask

    task automatic test_reset_config_access();
        // a read at the default bus address, write and read address bytes both sent
        run_access(OP_READ, 8'h3C, 8'h00, 8'h5A, 0, OP_TICK);
    endtask

    task automatic test_device_extremes();
        set_config(7'h00, '0);
        run_access(OP_WRITE, 8'hFF, 8'h00, 8'h00, 0, OP_TICK);
        run_access(OP_READ, 8'h00, 8'hFF, 8'hFF, 0, OP_TICK);
        set_config(7'h7F, WAIT_COUNT_BITS'(1));
        run_access(OP_WRITE, 8'h00, 8'hFF, 8'h00, 0, OP_TICK);
        run_access(OP_READ, 8'hFF, 8'h00, 8'h00, 0, OP_TICK);
        run_access(OP_READ, 8'hA5, 8'h5A, 8'hA5, 0, OP_TICK);
    endtask

    task automatic test_requests_while_busy();
        // each busy tick, completion too, carries a request to be dropped, or op_none
        set_config(7'h50, '0);
        run_access(OP_WRITE, 8'h81, 8'h7E, 8'h00, 100, OP_READ);
        run_access(OP_READ, 8'h18, 8'hE7, 8'h3C, 100, OP_WRITE);
        set_config(7'h50, WAIT_COUNT_BITS'(2));
        run_access(OP_WRITE, 8'h42, 8'h24, 8'h00, 100, OP_READ);
        run_access(OP_READ, 8'h99, 8'h66, 8'hC3, 100, OP_NONE);
    endtask

    task automatic test_max_write_wait();
        // longest write cycle time is only configured, reads must be unaffected by it
        set_config(7'h2A, {WAIT_COUNT_BITS{1'b1}});
        run_access(OP_READ, 8'h10, 8'h01, 8'h81, 0, OP_TICK);
        run_access(OP_READ, 8'hEF, 8'hFE, 8'h7E, 30, OP_NONE);
        set_config(7'h50, WAIT_COUNT_BITS'(5));
    endtask

    task automatic test_random(int src_pct, int sink_pct, int n_items);
        int stop_at;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = tick_cnt + n_items;
        set_config(7'($urandom_range(127)), pick_wait());
        while (tick_cnt < stop_at) begin
            if ($urandom_range(3) == 0) set_config(7'($urandom_range(127)), pick_wait());
            if ($urandom_range(99) < 85) begin
                run_access(op_t'($urandom_range(OP_WRITE, OP_READ)), 8'($urandom), 8'($urandom),
                           8'($urandom), $urandom_range(30), op_t'($urandom_range(OP_NONE)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_tick(op_t'($urandom_range(OP_NONE)), 8'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
            end
        end
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // result side: random backpressure, check each word the core hands over
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(negedge aclk) begin
        bus_word_t want;
        bus_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_bus_words.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word, expected none got %0h", $time, m_tdata);
            end else begin
                want = expected_bus_words.pop_front();
                report_field("scl_level", 32'(want.scl_level), 32'(got.scl_level));
                report_field("sda_release", 32'(want.sda_release), 32'(got.sda_release));
                report_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                report_field("done_res", 32'(want.done_res), 32'(got.done_res));
                report_field("read_data", 32'(want.read_data), 32'(got.read_data));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
                     expected_bus_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_reset_config_access();
        test_device_extremes();
        test_requests_while_busy();
        test_max_write_wait();
        test_random(19, 51, 100);
        test_random(51, 19, 100);
        test_random(0, 0, 100);
        drain_to_idle();
        if (expected_bus_words.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d words never arrived", $time, expected_bus_words.size());
        end
        $display("ran %0d ticks: %0d byte writes, %0d byte reads, %0d requests dropped while busy",
                 tick_cnt, write_cnt, read_cnt, ignored_req_cnt);
        $display("bus addresses 0 to 127, write waits 0 to max, with stalls on both sides");
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
